/* rtl/ubds_pkg.sv */
// Shared widths and constants for the UART baud divisor selector.
package ubds_pkg;

    localparam int ClkBits  = 28;
    localparam int BaudBits = 24;
    localparam int DivBits  = 28;
    localparam int Q16Bits  = ClkBits - 4;
    localparam int Q4Bits   = ClkBits - 2;
    localparam int ProdBits = ClkBits + 10;

    localparam logic [ClkBits-1:0]  ClockReset = 28'd40_000_000;
    localparam logic [ProdBits-1:0] ErrScale   = 38'd1000;
    localparam logic [ProdBits-1:0] ErrLimit   = 38'd25;
    localparam logic [15:0]         DivisorMax = 16'hFFFF;

    typedef struct packed {
        logic [1:0]          tag;
        logic [BaudBits-1:0] baud;
    } t_side;

    typedef struct packed {
        logic [1:0]          tag;
        logic [BaudBits-1:0] baud;
        logic [Q16Bits-1:0]  q16;
        logic [Q4Bits-1:0]   q4;
    } t_mid;

    typedef struct packed {
        logic [ClkBits-1:0] err;
        logic               take_second;
    } t_pick;

endpackage

/* rtl/uart_baud_divisor_select.sv */
// Top level of the UART baud divisor selector: pipeline, config register, output stage.
//
// Input transaction: i_uart_select and i_baud_rate on i_in_valid/o_in_ready.
// Output transaction: o_uart_target, o_divisor, o_high_speed, o_invalid on
// o_out_valid/i_out_ready. One result per input, in order.
// i_cfg_we writes i_cfg_data into the clock frequency register; write only when
// no transaction is in flight.
// A 28-stage divider forms clock/baud, one stage derives the divide-by-16
// and divide-by-4 quotients, four 28-stage dividers run in parallel for the
// candidate rates, one stage compares errors, one stage makes the final
// choice into the output register.
// Throughput is one transaction per cycle while the receiver keeps taking results.
// All stages share one advance enable: when the output holds a result that is
// not taken, the whole pipe freezes and o_in_ready drops; nothing is lost or
// repeated. Bubbles are carried, not squeezed out.
// Reset clears all valid bits and loads the clock register with 40 MHz.
module uart_baud_divisor_select (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ubds_pkg::ClkBits-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_uart_select,
    input  logic [ubds_pkg::BaudBits-1:0]     i_baud_rate,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_uart_target,
    output logic [15:0]                       o_divisor,
    output logic                              o_high_speed,
    output logic                              o_invalid
);

    localparam int N  = ubds_pkg::DivBits;
    localparam int W  = ubds_pkg::ClkBits;
    localparam int BW = ubds_pkg::BaudBits;
    localparam int QA = ubds_pkg::Q16Bits;
    localparam int QB = ubds_pkg::Q4Bits;
    localparam int PW = ubds_pkg::ProdBits;

    logic [W-1:0] r_clock_hz;
    logic         en;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= ubds_pkg::ClockReset;
        end else if (i_cfg_we) begin
            r_clock_hz <= i_cfg_data;
        end
    end

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // ---- first divider: clock / baud ----
    logic [W-1:0]    quo_main;
    logic            r_vld1 [N];
    ubds_pkg::t_side r_sb1  [N];

    ubds_div u_div_main (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_clock_hz (r_clock_hz),
        .i_divisor  (W'(i_baud_rate)),
        .o_quotient (quo_main)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) r_vld1[i] <= 1'b0;
        end else if (en) begin
            r_vld1[0] <= i_in_valid;
            for (int i = 1; i < N; i++) r_vld1[i] <= r_vld1[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb1[0].tag  <= i_uart_select;
            r_sb1[0].baud <= i_baud_rate;
            for (int i = 1; i < N; i++) r_sb1[i] <= r_sb1[i-1];
        end
    end

    // ---- quotient stage: q16 = (C/b)/16, q4 = (C/b)/4 ----
    logic           r_vld_p;
    ubds_pkg::t_mid r_mid_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_p <= 1'b0;
        end else if (en) begin
            r_vld_p <= r_vld1[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mid_p.tag  <= r_sb1[N-1].tag;
            r_mid_p.baud <= r_sb1[N-1].baud;
            r_mid_p.q16  <= quo_main[W-1:4];
            r_mid_p.q4   <= quo_main[W-1:2];
        end
    end

    // ---- candidate rate dividers: C/q and C/(q+1) for both modes ----
    logic [W-1:0]   quo_n_lo;
    logic [W-1:0]   quo_n_hi;
    logic [W-1:0]   quo_h_lo;
    logic [W-1:0]   quo_h_hi;
    logic           r_vld2 [N];
    ubds_pkg::t_mid r_sb2  [N];

    ubds_div u_div_n_lo (
        .i_clk(i_clk), .i_en(en), .i_clock_hz(r_clock_hz),
        .i_divisor(W'(r_mid_p.q16)), .o_quotient(quo_n_lo)
    );
    ubds_div u_div_n_hi (
        .i_clk(i_clk), .i_en(en), .i_clock_hz(r_clock_hz),
        .i_divisor(W'(r_mid_p.q16) + W'(1)), .o_quotient(quo_n_hi)
    );
    ubds_div u_div_h_lo (
        .i_clk(i_clk), .i_en(en), .i_clock_hz(r_clock_hz),
        .i_divisor(W'(r_mid_p.q4)), .o_quotient(quo_h_lo)
    );
    ubds_div u_div_h_hi (
        .i_clk(i_clk), .i_en(en), .i_clock_hz(r_clock_hz),
        .i_divisor(W'(r_mid_p.q4) + W'(1)), .o_quotient(quo_h_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) r_vld2[i] <= 1'b0;
        end else if (en) begin
            r_vld2[0] <= r_vld_p;
            for (int i = 1; i < N; i++) r_vld2[i] <= r_vld2[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb2[0] <= r_mid_p;
            for (int i = 1; i < N; i++) r_sb2[i] <= r_sb2[i-1];
        end
    end

    // ---- error compare stage ----
    ubds_pkg::t_pick pick_n;
    ubds_pkg::t_pick pick_h;

    ubds_pick u_pick_n (
        .i_high(1'b0), .i_baud(r_sb2[N-1].baud),
        .i_quo_lo(quo_n_lo), .i_quo_hi(quo_n_hi), .o_pick(pick_n)
    );
    ubds_pick u_pick_h (
        .i_high(1'b1), .i_baud(r_sb2[N-1].baud),
        .i_quo_lo(quo_h_lo), .i_quo_hi(quo_h_hi), .o_pick(pick_h)
    );

    logic          r_vld_e;
    logic [1:0]    r_tag_e;
    logic [BW-1:0] r_baud_e;
    logic          r_q16_zero_e;
    logic          r_q4_zero_e;
    logic [QA-1:0] r_cand16_e;
    logic [QB-1:0] r_cand4_e;
    logic [W-1:0]  r_err16_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_e <= 1'b0;
        end else if (en) begin
            r_vld_e <= r_vld2[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag_e      <= r_sb2[N-1].tag;
            r_baud_e     <= r_sb2[N-1].baud;
            r_q16_zero_e <= (r_sb2[N-1].q16 == '0);
            r_q4_zero_e  <= (r_sb2[N-1].q4 == '0);
            r_cand16_e   <= pick_n.take_second ? r_sb2[N-1].q16
                                               : r_sb2[N-1].q16 - QA'(1);
            r_cand4_e    <= pick_h.take_second ? r_sb2[N-1].q4
                                               : r_sb2[N-1].q4 - QB'(1);
            r_err16_e    <= pick_n.err;
        end
    end

    // ---- final choice into the output register ----
    logic [PW-1:0] err_scaled;
    logic [PW-1:0] err_bound;
    logic          go_high;
    logic [QB-1:0] n_cand;
    logic [1:0]    n_tag;
    logic [15:0]   n_divisor;
    logic          n_high;
    logic          n_invalid;

    // floor(err*1000/baud) > 25  <=>  err*1000 >= 26*baud
    assign err_scaled = PW'(r_err16_e) * ubds_pkg::ErrScale;
    assign err_bound  = PW'(r_baud_e) * (ubds_pkg::ErrLimit + PW'(1));
    assign go_high    = r_q16_zero_e || (err_scaled >= err_bound);

    always_comb begin
        n_tag     = r_tag_e;
        n_cand    = '0;
        n_high    = 1'b0;
        n_invalid = 1'b0;
        if (r_baud_e == '0) begin
            n_invalid = 1'b1;
        end else if (go_high) begin
            n_high = 1'b1;
            if (r_q4_zero_e) begin
                n_invalid = 1'b1;
            end else begin
                n_cand = r_cand4_e;
            end
        end else begin
            n_cand = QB'(r_cand16_e);
        end
        // saturate oversize divisors
        if (n_cand > QB'(ubds_pkg::DivisorMax)) begin
            n_divisor = ubds_pkg::DivisorMax;
            n_invalid = 1'b1;
        end else begin
            n_divisor = n_cand[15:0];
        end
    end

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld_e;
        end
    end

    logic [1:0]  r_tag_o;
    logic [15:0] r_divisor_o;
    logic        r_high_o;
    logic        r_invalid_o;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag_o     <= n_tag;
            r_divisor_o <= n_divisor;
            r_high_o    <= n_high;
            r_invalid_o <= n_invalid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_uart_target = r_tag_o;
    assign o_divisor     = r_divisor_o;
    assign o_high_speed  = r_high_o;
    assign o_invalid     = r_invalid_o;

endmodule

/* rtl/ubds_div.sv */
// Pipelined restoring divider: clock value over a divisor, one quotient bit per stage.
module ubds_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [ubds_pkg::ClkBits-1:0]   i_clock_hz,
    input  logic [ubds_pkg::DivBits-1:0]   i_divisor,
    output logic [ubds_pkg::ClkBits-1:0]   o_quotient
);

    localparam int N = ubds_pkg::DivBits;
    localparam int W = ubds_pkg::ClkBits;

    logic [W-1:0] r_rem [N];
    logic [W-1:0] r_quo [N];
    logic [N-1:0] r_dvs [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [W-1:0] rem_in;
        logic [W-1:0] quo_in;
        logic [N-1:0] dvs_in;
        logic [W:0]   trial;
        logic [W-1:0] n_rem;
        logic         n_bit;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign dvs_in = i_divisor;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign dvs_in = r_dvs[s-1];
        end

        // user holds dividend static while items in flight (unchecked); bits MSB first
        assign trial = {rem_in, i_clock_hz[W-1-s]};

        always_comb begin
            if (trial >= {1'b0, dvs_in}) begin
                n_bit = 1'b1;
                n_rem = W'(trial - {1'b0, dvs_in});
            end else begin
                n_bit = 1'b0;
                n_rem = trial[W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= {quo_in[W-2:0], n_bit};
                r_dvs[s] <= dvs_in;
            end
        end
    end

    assign o_quotient = r_quo[N-1];

endmodule

/* rtl/ubds_pick.sv */
// Candidate compare: actual rates of q-1 and q, absolute errors, pick the better one.
module ubds_pick (
    input  logic                            i_high,
    input  logic [ubds_pkg::BaudBits-1:0]   i_baud,
    input  logic [ubds_pkg::ClkBits-1:0]    i_quo_lo,
    input  logic [ubds_pkg::ClkBits-1:0]    i_quo_hi,
    output ubds_pkg::t_pick                 o_pick
);

    localparam int W = ubds_pkg::ClkBits;

    logic [W-1:0] rate1;
    logic [W-1:0] rate2;
    logic [W-1:0] baud_w;
    logic [W-1:0] err1;
    logic [W-1:0] err2;

    // C/(d*m) == (C/m)/d
    assign rate1  = i_high ? (i_quo_lo >> 2) : (i_quo_lo >> 4);
    assign rate2  = i_high ? (i_quo_hi >> 2) : (i_quo_hi >> 4);
    assign baud_w = W'(i_baud);
    assign err1   = (rate1 > baud_w) ? (rate1 - baud_w) : (baud_w - rate1);
    assign err2   = (rate2 > baud_w) ? (rate2 - baud_w) : (baud_w - rate2);

    // tie goes to the second candidate
    assign o_pick.take_second = !(err1 < err2);
    assign o_pick.err         = (err1 < err2) ? err1 : err2;

endmodule

/* bench/uart_baud_divisor_select_tb.sv */
// Self-checking testbench for the UART baud divisor selector.
module uart_baud_divisor_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Pipeline latency of the DUT, plus margin for the drain.
    localparam int LatencyCycles = 59;
    localparam int DrainCycles   = LatencyCycles + 20;
    localparam int CycleLimit    = 400000;

    typedef struct packed {
        logic [1:0]  tag;
        logic [15:0] divisor;
        logic        high_speed;
        logic        invalid;
    } t_divisor_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [ubds_pkg::ClkBits-1:0]  i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [1:0]                    i_uart_select = '0;
    logic [ubds_pkg::BaudBits-1:0] i_baud_rate = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [1:0]                    o_uart_target;
    logic [15:0]                   o_divisor;
    logic                          o_high_speed;
    logic                          o_invalid;

    // Predictor's own copy of the clock register.
    logic [ubds_pkg::ClkBits-1:0]  clock_hz_model = ubds_pkg::ClockReset;
    t_divisor_result               divisor_queue[$];
    int                            error_count = 0;
    int                            cycle_count = 0;
    int                            send_idle_pct = 0;
    int                            recv_idle_pct = 0;

    uart_baud_divisor_select dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_uart_select (i_uart_select),
        .i_baud_rate   (i_baud_rate),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_uart_target (o_uart_target),
        .o_divisor     (o_divisor),
        .o_high_speed  (o_high_speed),
        .o_invalid     (o_invalid)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: any hang ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Pick the closer of candidates q-1 and q for one divider; ties go to q.
    function automatic logic [63:0] best_candidate(input logic [63:0] baud,
                                                   input logic [63:0] divider,
                                                   input logic [63:0] q,
                                                   output logic [63:0] err);
        logic [63:0] rate_lo, rate_hi, err_lo, err_hi;
        rate_lo = clock_hz_model / (divider * q);
        rate_hi = clock_hz_model / (divider * (q + 1));
        err_lo  = (rate_lo > baud) ? rate_lo - baud : baud - rate_lo;
        err_hi  = (rate_hi > baud) ? rate_hi - baud : baud - rate_hi;
        if (err_lo < err_hi) begin
            err = err_lo;
            return q - 1;
        end
        err = err_hi;
        return q;
    endfunction

    function automatic t_divisor_result predict_divisor(input logic [1:0] tag,
                                                        input logic [23:0] baud_in);
        t_divisor_result r;
        logic [63:0] baud, q, div, err;
        logic        to_high;
        baud    = 64'(baud_in);
        div     = 0;
        err     = 0;
        to_high = 1'b0;
        r       = '0;
        r.tag   = tag;
        if (baud == 0) begin
            r.invalid = 1'b1;
            return r;
        end
        q = clock_hz_model / (16 * baud);
        if (q == 0) begin
            // Unreachable at divide-by-16: go straight to divide-by-4.
            to_high = 1'b1;
        end else begin
            div = best_candidate(baud, 16, q, err);
            if ((err * 1000) / baud > 25) to_high = 1'b1;
        end
        if (to_high) begin
            r.high_speed = 1'b1;
            q = clock_hz_model / (4 * baud);
            if (q == 0) begin
                div       = 0;
                r.invalid = 1'b1;
            end else begin
                div = best_candidate(baud, 4, q, err);
            end
        end
        if (div > 65535) begin
            div       = 65535;
            r.invalid = 1'b1;
        end
        r.divisor = div[15:0];
        return r;
    endfunction

    // Receiver: random stalls, compare each result against the oldest prediction.
    always @(posedge i_clk) begin
        t_divisor_result got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_uart_target, o_divisor, o_high_speed, o_invalid};
            if (divisor_queue.size() == 0) begin
                $display("%0t unexpected result: actual %p", $time, got);
                error_count++;
            end else begin
                want = divisor_queue.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, got);
                    error_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one request transaction; the prediction is queued at acceptance.
    // Valid stays high into the next call so back-to-back sends have no gap.
    task automatic send_request(input logic [1:0] tag, input logic [23:0] baud);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_uart_select <= tag;
        i_baud_rate   <= baud;
        do @(posedge i_clk); while (!o_in_ready);
        divisor_queue.push_back(predict_divisor(tag, baud));
        @(negedge i_clk);
    endtask

    // Wait for the pipe to drain, then write the clock register.
    task automatic set_clock(input logic [ubds_pkg::ClkBits-1:0] hz);
        i_in_valid <= 1'b0;
        while (divisor_queue.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= hz;
        @(negedge i_clk);
        i_cfg_we       <= 1'b0;
        clock_hz_model  = hz;
    endtask

    // Baud rates spread over common, small and full-range values.
    function automatic logic [23:0] random_baud();
        case ($urandom_range(5))
            0: return 24'($urandom_range(1, 300));
            1: return 24'($urandom_range(300, 120000));
            2: return 24'($urandom_range(120000, 4000000));
            3: return 24'($urandom);
            4: begin
                logic [23:0] std_rates[8] = '{1200, 2400, 9600, 19200, 38400,
                                               57600, 115200, 921600};
                return std_rates[$urandom_range(7)];
            end
            default: return 24'(clock_hz_model / (4 * $urandom_range(1, 64)));
        endcase
    endfunction

    task automatic test_directed();
        send_request(2'd0, 24'd0);          // zero baud
        send_request(2'd3, 24'hFFFFFF);     // largest baud: zero quotient both modes
        send_request(2'd1, 24'd1);          // smallest baud: saturated divisor
        send_request(2'd2, 24'd9600);
        send_request(2'd1, 24'd115200);
        send_request(2'd0, 24'd2500000);    // exact rate at divide-by-16
        send_request(2'd3, 24'd9000000);    // zero quotient at 16, fine at 4
        send_request(2'd2, 24'd11000000);   // zero quotient at 4
        send_request(2'd1, 24'd610);        // low rate, divisor well below saturation
        send_request(2'd0, 24'h555555);
        send_request(2'd3, 24'hAAAAAA);
        set_clock(28'd0);                   // zero clock
        send_request(2'd0, 24'd9600);
        send_request(2'd2, 24'd0);
        set_clock(28'hFFFFFFF);             // largest clock
        send_request(2'd1, 24'd1);
        send_request(2'd2, 24'd57600);
        send_request(2'd3, 24'hFFFFFF);
        set_clock(28'd1);
        send_request(2'd0, 24'd1);
        set_clock(28'd200000000);
        send_request(2'd1, 24'd3);
        send_request(2'd2, 24'd12500000);
    endtask

    task automatic test_random(input int n_items, input int sidle, input int ridle);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int i = 0; i < n_items; i++) begin
            if (i % 70 == 0) begin
                case ($urandom_range(3))
                    0: set_clock(28'($urandom_range(1, 200000000)));
                    1: set_clock(28'($urandom));
                    2: set_clock(28'd40000000);
                    default: set_clock(28'($urandom_range(1000, 2000000)));
                endcase
            end
            send_request(2'($urandom), random_baud());
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(280, 37, 54);
        test_random(280, 54, 37);
        test_random(280, 0, 0);
        i_in_valid <= 1'b0;
        while (divisor_queue.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
